// ----- src/ced_pkg.sv -----
// shared types, character codes and helpers for the c escape sequence decoder
// depends on nothing; used by every module in src
package ced_pkg;

	localparam int CAP_BITS     = 16;
	localparam int FIFO_DEPTH   = 8;
	localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
	localparam int MAX_RES      = 3;

	// decoder modes
	localparam logic [2:0] M_NORMAL = 3'd0;
	localparam logic [2:0] M_ESC    = 3'd1;
	localparam logic [2:0] M_HEX0   = 3'd2;
	localparam logic [2:0] M_HEX    = 3'd3;
	localparam logic [2:0] M_OCT    = 3'd4;

	// character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_N   = 8'h6E;
	localparam logic [7:0] CH_LC_R   = 8'h72;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_LC_V   = 8'h76;
	localparam logic [7:0] CH_LC_X   = 8'h78;
	localparam logic [7:0] CH_BEL    = 8'h07;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_HT     = 8'h09;
	localparam logic [7:0] CH_VT     = 8'h0B;

	typedef struct packed {
		logic [15:0] out_length;
		logic        is_last;
		logic [7:0]  out_byte;
	} result_t;

	typedef struct packed {
		logic [1:0]  count;
		result_t [MAX_RES-1:0] item;
	} res_list_t;

	typedef struct packed {
		logic [2:0]          mode;
		logic [7:0]          digit_value;
		logic [1:0]          digit_count;
		logic [CAP_BITS-1:0] room_left;
		logic [15:0]         written_count;
		logic                at_string_start;
	} dec_state_t;

	// hex digit value; bit 4 marks a valid digit
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	function automatic logic is_oct(input logic [7:0] c);
		return c[7:3] == 5'b00110;
	endfunction

endpackage

// ----- src/ced_decode.sv -----
// escape decoder: holds the string state and turns one source byte into
// up to three results in a single pass; uses ced_pkg
module ced_decode (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [7:0]                   src_byte,
	input  logic [15:0]                  out_capacity,
	output ced_pkg::res_list_t           res
);
	import ced_pkg::*;

	dec_state_t st_q;
	dec_state_t st_d;

	function automatic void put(inout res_list_t r, input logic [7:0] b,
			input logic last, input logic [15:0] len);
		r.item[r.count] = '{out_length: len, is_last: last, out_byte: b};
		r.count = r.count + 2'd1;
	endfunction

	function automatic void emit(inout dec_state_t s, inout res_list_t r,
			input logic [7:0] b);
		if (s.room_left > CAP_BITS'(1)) begin
			put(r, b, 1'b0, 16'd0);
			s.room_left = s.room_left - CAP_BITS'(1);
			s.written_count = s.written_count + 16'd1;
		end
	endfunction

	function automatic void finish(inout dec_state_t s, inout res_list_t r);
		if (s.room_left != '0) begin
			put(r, CH_NUL, 1'b1, s.written_count + 16'd1);
			s.room_left = s.room_left - CAP_BITS'(1);
		end
		s.mode = M_NORMAL;
		s.digit_value = 8'd0;
		s.digit_count = 2'd0;
		s.at_string_start = 1'b1;
	endfunction

	function automatic void plain(inout dec_state_t s, inout res_list_t r,
			input logic [7:0] c);
		s.mode = M_NORMAL;
		if (c == CH_NUL)
			finish(s, r);
		else if (s.room_left <= CAP_BITS'(1)) begin
			// capacity used up, byte dropped
		end else if (c == CH_BSLASH)
			s.mode = M_ESC;
		else
			emit(s, r, c);
	endfunction

	always_comb begin
		dec_state_t s;
		res_list_t  r;
		logic [4:0] h;
		logic [7:0] c;
		s = st_q;
		r = '0;
		c = src_byte;
		h = hex_val(c);
		if (s.at_string_start) begin
			s.room_left = CAP_BITS'(out_capacity);
			s.written_count = 16'd0;
			s.at_string_start = 1'b0;
			s.mode = M_NORMAL;
		end
		unique case (s.mode)
			M_ESC: begin
				s.mode = M_NORMAL;
				case (c)
					CH_NUL:    finish(s, r);
					CH_NL:     ;
					CH_BSLASH: emit(s, r, CH_BSLASH);
					CH_LC_A:   emit(s, r, CH_BEL);
					CH_LC_B:   emit(s, r, CH_BS);
					CH_LC_F:   emit(s, r, CH_FF);
					CH_LC_N:   emit(s, r, CH_NL);
					CH_LC_R:   emit(s, r, CH_CR);
					CH_LC_T:   emit(s, r, CH_HT);
					CH_LC_V:   emit(s, r, CH_VT);
					CH_LC_X: begin
						s.digit_value = 8'd0;
						s.mode = M_HEX0;
					end
					default: begin
						if (is_oct(c)) begin
							s.digit_value = {5'd0, c[2:0]};
							s.digit_count = 2'd1;
							s.mode = M_OCT;
						end else begin
							// unknown escape: backslash out, byte taken as text
							emit(s, r, CH_BSLASH);
							plain(s, r, c);
						end
					end
				endcase
			end
			M_HEX0: begin
				if (h[4]) begin
					s.digit_value = {4'd0, h[3:0]};
					s.mode = M_HEX;
				end else begin
					emit(s, r, CH_BSLASH);
					emit(s, r, CH_LC_X);
					plain(s, r, c);
				end
			end
			M_HEX: begin
				if (h[4])
					s.digit_value = {s.digit_value[3:0], h[3:0]};
				else begin
					emit(s, r, s.digit_value);
					s.digit_value = 8'd0;
					plain(s, r, c);
				end
			end
			M_OCT: begin
				if (is_oct(c)) begin
					s.digit_value = {s.digit_value[4:0], c[2:0]};
					s.digit_count = s.digit_count + 2'd1;
					if (s.digit_count == 2'd3) begin
						emit(s, r, s.digit_value);
						s.digit_value = 8'd0;
						s.digit_count = 2'd0;
						s.mode = M_NORMAL;
					end
				end else begin
					emit(s, r, s.digit_value);
					s.digit_value = 8'd0;
					s.digit_count = 2'd0;
					plain(s, r, c);
				end
			end
			default: plain(s, r, c);
		endcase
		st_d = s;
		res = r;
		if (!step)
			res.count = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{mode: M_NORMAL, digit_value: 8'd0, digit_count: 2'd0,
				room_left: '0, written_count: 16'd0, at_string_start: 1'b1};
		end else if (step) begin
			st_q <= st_d;
		end
	end

endmodule

// ----- src/ced_result_fifo.sv -----
// result queue: takes up to three results a cycle, hands out one while m_tready is high
// uses ced_pkg for the result type and depth
module ced_result_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ced_pkg::res_list_t           push,
	output logic                         room3,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output ced_pkg::result_t             head
);
	import ced_pkg::*;

	result_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]  wr_ptr_q;
	logic [FIFO_AW-1:0]  rd_ptr_q;
	logic [FIFO_AW:0]    count_q;
	logic                pop;

	assign m_tvalid = count_q != '0;
	assign pop      = m_tvalid && m_tready;
	assign head     = mem_q[rd_ptr_q];
	// space for a worst-case item, ignoring this cycle's pop
	assign room3    = count_q <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_RES);

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (2'(i) < push.count)
				mem_q[wr_ptr_q + FIFO_AW'(i)] <= push.item[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push.count);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			count_q <= count_q + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop);
		end
	end

endmodule

// ----- src/c_escape_sequence_decoder.sv -----
// top level of the c escape sequence decoder: input register, decoder,
// result queue; depends on ced_pkg, ced_decode and ced_result_fifo
//
// usage:
//  slave channel carries source text, one byte per transaction; a zero
//  byte ends the string. out_capacity is sampled on the first byte of
//  each string.
//  master channel carries decoded bytes; the terminating zero has tlast
//  high and carries the string length (terminator included).
//  the input register holds each byte and the decoder writes its results
//  into the result queue, from which the first of them is offered.
//  throughput: one byte per cycle; a byte yields zero to three results,
//  all written to an eight-entry result queue at once, and input is
//  held while the queue has fewer than three free entries.
//  reset: queue empty, decoder in plain text mode, next byte starts a
//  new string.
//  receiver stall: the queue fills, then the input register holds and
//  s_tready drops; nothing is lost.
module c_escape_sequence_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] src_byte, [23:8] out_capacity
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] out_length
	output logic        m_tlast    // is_last
);
	import ced_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [15:0] cap_s1;
	logic        room3;
	logic        step;
	res_list_t   res;
	result_t     head;

	assign step     = valid_s1 && room3;
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[7:0];
			cap_s1  <= s_tdata[23:8];
		end
	end

	ced_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.src_byte     (byte_s1),
		.out_capacity (cap_s1),
		.res          (res)
	);

	ced_result_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res),
		.room3    (room3),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.head     (head)
	);

	assign m_tdata = {head.out_length, head.out_byte};
	assign m_tlast = head.is_last;

endmodule
